// File: src/fla_pkg.sv
// package for the free-list block allocator: default sizes and shared widths
// no dependencies; used by the top level and the port checker
`default_nettype none
package fla_pkg;
  // default arena depth in units and log2 of the unit size in bytes
  localparam int unsigned ArenaDepthDef  = 1024;
  localparam int unsigned UnitLog2Def    = 6;
  // fixed field widths
  localparam int unsigned BytesW         = 16;
  localparam int unsigned UnitW          = 10;
  localparam int unsigned ArenaW         = 11;
  // width of size and address arithmetic, wide enough for every sum
  localparam int unsigned CalcW          = 18;
  // operation codes
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;
endpackage
`default_nettype wire

// File: src/fla_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module fla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: src/free_list_block_allocator.sv
// free-list block allocator top level: fsm walking the free list in two rams
// depends on fla_pkg and fla_ram
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+-----------------------------------
//  command   | start_i, busy_o               | op_i, request_bytes_i, block_unit_i
//  result    | done_o (one-cycle strobe)     | granted_o, data_unit_o
//  config    | cfg_valid_i, cfg_ready_o      | arena_units_i
//
// an allocate reads the rover's link, then checks free-list links in turn
// and carves the block when the fit is not exact; a free walks the list,
// then merges neighbors; a null or out-of-arena free answers at once.
// the walk is paced by the one read port of the link and size rams.
// after reset and after each arena size write, S_INIT rebuilds the list.
// results are strobed for one cycle; the receiver cannot stall them.
`default_nettype none
module free_list_block_allocator #(
  parameter int unsigned ARENA_DEPTH     = fla_pkg::ArenaDepthDef,
  parameter int unsigned UNIT_LOG2_BYTES = fla_pkg::UnitLog2Def
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          op_i,
  input  wire logic [fla_pkg::BytesW-1:0]    request_bytes_i,
  input  wire logic [fla_pkg::UnitW-1:0]     block_unit_i,
  output logic                               done_o,
  output logic                               granted_o,
  output logic      [fla_pkg::UnitW-1:0]     data_unit_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [fla_pkg::ArenaW-1:0]    arena_units_i
);
  localparam int unsigned AW = $clog2(ARENA_DEPTH);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned CW = fla_pkg::CalcW;
  localparam int unsigned LIMIT = ARENA_DEPTH + 1;
  localparam logic [CW-1:0] UnitMask = CW'((1 << UNIT_LOG2_BYTES) - 1);
  localparam logic [SW-1:0] ArenaRst = SW'(ARENA_DEPTH < 1024 ? ARENA_DEPTH : 1024);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_INIT   = 11'b000_0000_0010,
    S_AFIRST = 11'b000_0000_0100,
    S_ACHECK = 11'b000_0000_1000,
    S_ACARVE = 11'b000_0001_0000,
    S_FWALK  = 11'b000_0010_0000,
    S_FRNX   = 11'b000_0100_0000,
    S_FRP    = 11'b000_1000_0000,
    S_FWBP   = 11'b001_0000_0000,
    S_FWP    = 11'b010_0000_0000,
    S_FDONE  = 11'b100_0000_0000
  } state_e;

  state_e         state_q, state_d;
  logic [SW-1:0]  arena_q, arena_d;
  logic [AW-1:0]  rover_q, rover_d;
  logic [AW-1:0]  cur_q, cur_d;
  logic [AW-1:0]  prev_q, prev_d;
  logic [AW-1:0]  bp_q, bp_d;
  logic [AW-1:0]  nx_q, nx_d;
  logic [AW-1:0]  carve_q, carve_d;
  logic [CW-1:0]  need_q, need_d;
  logic [SW-1:0]  size_bp_q, size_bp_d;
  logic [SW-1:0]  size_nx_q, size_nx_d;
  logic [AW-1:0]  link_nx_q, link_nx_d;
  logic [SW-1:0]  size_p_q, size_p_d;
  logic [AW:0]    steps_q, steps_d;
  logic           done_q, done_d;
  logic           granted_q, granted_d;
  logic [fla_pkg::UnitW-1:0] unit_q, unit_d;

  // ram ports
  logic [AW-1:0]  rd_addr;
  logic           link_we, size_we;
  logic [AW-1:0]  link_waddr, size_waddr;
  logic [AW-1:0]  link_wdata, link_rdata;
  logic [SW-1:0]  size_wdata, size_rdata;

  fla_ram #(.WIDTH(AW), .DEPTH(ARENA_DEPTH)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (rd_addr),
    .rdata_o (link_rdata)
  );

  fla_ram #(.WIDTH(SW), .DEPTH(ARENA_DEPTH)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (size_waddr),
    .wdata_i (size_wdata),
    .raddr_i (rd_addr),
    .rdata_o (size_rdata)
  );

  // request decode
  logic [CW-1:0] need_w;
  logic [fla_pkg::UnitW-1:0] bp_w;
  logic [CW-1:0] cfg_w;
  assign need_w = ((CW'(request_bytes_i) + UnitMask) >> UNIT_LOG2_BYTES) + CW'(1);
  assign bp_w   = block_unit_i - fla_pkg::UnitW'(1);
  assign cfg_w  = CW'(arena_units_i);

  // fit test on the entry under the search
  logic [CW-1:0] size_c_w, rem_w;
  logic          fits, exact;
  assign size_c_w = CW'(size_rdata);
  assign fits     = size_c_w >= need_q;
  assign exact    = size_c_w == need_q;
  assign rem_w    = size_c_w - need_q;

  // place test on the free walk
  logic found;
  assign found = (bp_q > cur_q && bp_q < link_rdata) ||
                 (cur_q >= link_rdata && (bp_q > cur_q || bp_q < link_rdata));

  // merge with neighbors
  logic          upper, lower;
  logic [SW-1:0] new_size_bp;
  logic [AW-1:0] new_link_bp;
  assign upper = (CW'(bp_q) + CW'(size_bp_q)) == CW'(nx_q);
  assign new_size_bp = upper ? size_bp_q + size_nx_q : size_bp_q;
  assign new_link_bp = upper ? link_nx_q : nx_q;
  assign lower = (CW'(cur_q) + CW'(size_p_q)) == CW'(bp_q);

  // next-state and datapath
  always_comb begin
    state_d   = state_q;
    arena_d   = arena_q;
    rover_d   = rover_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    bp_d      = bp_q;
    nx_d      = nx_q;
    carve_d   = carve_q;
    need_d    = need_q;
    size_bp_d = size_bp_q;
    size_nx_d = size_nx_q;
    link_nx_d = link_nx_q;
    size_p_d  = size_p_q;
    steps_d   = steps_q;
    done_d    = 1'b0;
    granted_d = granted_q;
    unit_d    = unit_q;
    rd_addr    = rover_q;
    link_we    = 1'b0;
    size_we    = 1'b0;
    link_waddr = cur_q;
    size_waddr = cur_q;
    link_wdata = link_rdata;
    size_wdata = size_rdata;

    case (state_q)
      // an item takes precedence over a size write
      S_IDLE: begin
        if (start_i) begin
          steps_d = '0;
          cur_d   = rover_q;
          prev_d  = rover_q;
          if (op_i == fla_pkg::OpAlloc) begin
            need_d  = need_w;
            state_d = S_AFIRST;
          end else if (block_unit_i == '0) begin
            done_d    = 1'b1;
            granted_d = 1'b1;
            unit_d    = '0;
          end else if (bp_w == '0 || CW'(bp_w) >= CW'(arena_q)) begin
            done_d    = 1'b1;
            granted_d = 1'b0;
            unit_d    = '0;
          end else begin
            bp_d    = AW'(bp_w);
            state_d = S_FWALK;
          end
        end else if (cfg_valid_i) begin
          if (cfg_w < CW'(2)) begin
            arena_d = SW'(2);
          end else if (cfg_w > CW'(ARENA_DEPTH)) begin
            arena_d = SW'(ARENA_DEPTH);
          end else begin
            arena_d = SW'(cfg_w);
          end
          state_d = S_INIT;
        end
      end
      // one-block list over every unit of the arena but unit 0
      S_INIT: begin
        link_we    = 1'b1;
        link_waddr = AW'(1);
        link_wdata = AW'(1);
        size_we    = 1'b1;
        size_waddr = AW'(1);
        size_wdata = arena_q - SW'(1);
        rover_d    = AW'(1);
        state_d    = S_IDLE;
      end
      S_AFIRST: begin
        cur_d   = link_rdata;
        rd_addr = link_rdata;
        state_d = S_ACHECK;
      end
      S_ACHECK: begin
        if (fits) begin
          rover_d = prev_q;
          if (exact) begin
            link_we    = 1'b1;
            link_waddr = prev_q;
            link_wdata = link_rdata;
            done_d     = 1'b1;
            granted_d  = 1'b1;
            unit_d     = fla_pkg::UnitW'(CW'(cur_q) + CW'(1));
            state_d    = S_IDLE;
          end else begin
            size_we    = 1'b1;
            size_waddr = cur_q;
            size_wdata = SW'(rem_w);
            carve_d    = AW'(CW'(cur_q) + rem_w);
            state_d    = S_ACARVE;
          end
        end else if (cur_q == rover_q || steps_q == (AW+1)'(LIMIT - 1)) begin
          done_d    = 1'b1;
          granted_d = 1'b0;
          unit_d    = '0;
          state_d   = S_IDLE;
        end else begin
          prev_d  = cur_q;
          cur_d   = link_rdata;
          rd_addr = link_rdata;
          steps_d = steps_q + (AW+1)'(1);
        end
      end
      S_ACARVE: begin
        size_we    = 1'b1;
        size_waddr = carve_q;
        size_wdata = SW'(need_q);
        done_d     = 1'b1;
        granted_d  = 1'b1;
        unit_d     = fla_pkg::UnitW'(CW'(carve_q) + CW'(1));
        state_d    = S_IDLE;
      end
      // cur_q holds the walk position, link_rdata its successor
      S_FWALK: begin
        if (found) begin
          nx_d    = link_rdata;
          rd_addr = bp_q;
          state_d = S_FRNX;
        end else if (steps_q == (AW+1)'(LIMIT - 1)) begin
          done_d    = 1'b1;
          granted_d = 1'b0;
          unit_d    = '0;
          state_d   = S_IDLE;
        end else begin
          cur_d   = link_rdata;
          rd_addr = link_rdata;
          steps_d = steps_q + (AW+1)'(1);
        end
      end
      S_FRNX: begin
        size_bp_d = size_rdata;
        rd_addr   = nx_q;
        state_d   = S_FRP;
      end
      S_FRP: begin
        size_nx_d = size_rdata;
        link_nx_d = link_rdata;
        rd_addr   = cur_q;
        state_d   = S_FWBP;
      end
      S_FWBP: begin
        size_p_d = size_rdata;
        state_d  = S_FWP;
      end
      // write the freed header, then the lower neighbor
      S_FWP: begin
        link_we    = 1'b1;
        link_waddr = bp_q;
        link_wdata = new_link_bp;
        size_we    = upper;
        size_waddr = bp_q;
        size_wdata = new_size_bp;
        state_d    = S_FDONE;
      end
      S_FDONE: begin
        link_we    = 1'b1;
        link_waddr = cur_q;
        link_wdata = lower ? new_link_bp : bp_q;
        size_we    = lower;
        size_waddr = cur_q;
        size_wdata = size_p_q + new_size_bp;
        rover_d    = cur_q;
        done_d     = 1'b1;
        granted_d  = 1'b1;
        unit_d     = '0;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      arena_q <= ArenaRst;
      rover_q <= AW'(1);
      steps_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      arena_q <= arena_d;
      rover_q <= rover_d;
      steps_q <= steps_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    bp_q      <= bp_d;
    nx_q      <= nx_d;
    carve_q   <= carve_d;
    need_q    <= need_d;
    size_bp_q <= size_bp_d;
    size_nx_q <= size_nx_d;
    link_nx_q <= link_nx_d;
    size_p_q  <= size_p_d;
    granted_q <= granted_d;
    unit_q    <= unit_d;
  end

  assign busy_o      = state_q != S_IDLE;
  assign cfg_ready_o = (state_q == S_IDLE) && !start_i;
  assign done_o      = done_q;
  assign granted_o   = granted_q;
  assign data_unit_o = unit_q;
endmodule
`default_nettype wire

// File: src/fla_checker.sv
// port checker for the free-list block allocator, bound to the top level
// depends on fla_pkg
`default_nettype none
module fla_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start_i,
  input wire logic                       busy_o,
  input wire logic                       done_o,
  input wire logic                       granted_o,
  input wire logic [fla_pkg::UnitW-1:0]  data_unit_o,
  input wire logic                       cfg_valid_i,
  input wire logic                       cfg_ready_o
);
  // a result is only shown while the block is idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");

  // an accepted item either answers at once or keeps the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("item dropped");

  // a failed item never carries a data unit
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !granted_o) |-> (data_unit_o == '0)) else $error("failure with data");

  // an arena size write rebuilds the list before any item
  a_cfg_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> (busy_o && !done_o)) else $error("no rebuild");
endmodule

bind free_list_block_allocator fla_checker u_fla_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .granted_o   (granted_o),
  .data_unit_o (data_unit_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
`default_nettype wire
